FILE: hw/rtl/rgb_to_hsv_hsl_unit_macros.svh
// Assertion macros for the RGB to HSV/HSL converter.
// Used by the top level; expects signals named clk and arst_n in scope.
`ifndef RGB_TO_HSV_HSL_UNIT_MACROS_SVH
`define RGB_TO_HSV_HSL_UNIT_MACROS_SVH

// Checks that a condition holds at every clock edge out of reset.
`define RHH_ASSERT(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("rgb_to_hsv_hsl_unit: assertion failed");

// Checks that a trigger implies a consequence in the same cycle.
`define RHH_ASSERT_IMP(lbl, trig, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cons)) \
		else $error("rgb_to_hsv_hsl_unit: implication failed");

`endif

FILE: hw/rtl/rhh_pkg.sv
// Shared types, constants and the divider step for the RGB to HSV/HSL converter.
// No dependencies; used by rhh_front, rhh_div_cell and the top level.
package rhh_pkg;

	// Number of restoring division steps, one per cell in the chain.
	localparam int DIV_STEPS = 17;
	// Hue numerator scale: twice the 1/64-degree sector width of 3840.
	localparam int HUE_SCALE_X2 = 7680;
	// Field widths.
	localparam int CH_W = 8;
	localparam int HUE_W = 15;
	localparam int SAT_W = 17;
	localparam int LEVEL_W = 9;
	localparam int REM_W = 9;
	localparam int IN_DATA_W = 24;
	localparam int OUT_DATA_W = 48;

	// One division lane: partial remainder, dividend/quotient shift word, divisor.
	typedef struct packed {
		logic [REM_W-1:0]     rem;
		logic [DIV_STEPS-1:0] sh;
		logic [REM_W-1:0]     div;
	} lane_t;

	// Everything one cell hands to the next.
	typedef struct packed {
		lane_t               hue;
		lane_t               sat;
		logic                undef;
		logic                sat_zero;
		logic [LEVEL_W-1:0]  level;
	} cell_t;

	// One restoring division step: bring down the next dividend bit,
	// subtract the divisor when it fits and shift in the quotient bit.
	function automatic lane_t div_step(input lane_t l);
		logic [REM_W:0] r2;
		logic           ge;
		lane_t          o;
		r2 = {l.rem, l.sh[DIV_STEPS-1]};
		ge = (r2 >= {1'b0, l.div});
		o.div = l.div;
		o.rem = ge ? REM_W'(r2 - {1'b0, l.div}) : r2[REM_W-1:0];
		o.sh = {l.sh[DIV_STEPS-2:0], ge};
		return o;
	endfunction

endpackage

FILE: hw/rtl/rhh_front.sv
// Front stage: max/min, chroma, hue sector numerator and the divider operands.
// Depends on rhh_pkg.
module rhh_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        valid_in,
	input  logic [rhh_pkg::CH_W-1:0]    red,
	input  logic [rhh_pkg::CH_W-1:0]    green,
	input  logic [rhh_pkg::CH_W-1:0]    blue,
	input  logic                        mode,
	output logic                        valid_out,
	output rhh_pkg::cell_t              data_out
);

	logic [7:0]  mx;
	logic [7:0]  mn;
	logic [7:0]  c;
	logic [10:0] c2;
	logic [10:0] c4;
	logic [10:0] num;
	logic [23:0] xh;
	logic [8:0]  sum;
	logic [7:0]  den;
	rhh_pkg::cell_t nxt;
	logic           valid_s1;
	rhh_pkg::cell_t data_s1;

	// Channel extremes and chroma.
	always_comb begin
		mx = red;
		mn = red;
		if (green > mx) mx = green;
		if (blue > mx) mx = blue;
		if (green < mn) mn = green;
		if (blue < mn) mn = blue;
		c = mx - mn;
	end

	// Hue numerator by sector; green wins ties, then blue, then red.
	// The result is never negative, so modular 11-bit arithmetic is exact.
	always_comb begin
		c2 = {2'b00, c, 1'b0};
		c4 = {1'b0, c, 2'b00};
		priority if (mx == green) begin
			num = c2 + 11'(blue) - 11'(red);
		end else if (mx == blue) begin
			num = c4 + 11'(red) - 11'(green);
		end else if (green < blue) begin
			num = c4 + c2 + 11'(green) - 11'(blue);
		end else begin
			num = 11'(green) - 11'(blue);
		end
		xh = 24'(num) * 24'(rhh_pkg::HUE_SCALE_X2) + 24'(c);
	end

	// Saturation denominator and level for the selected mode.
	always_comb begin
		sum = {1'b0, mx} + {1'b0, mn};
		if (mode) begin
			den = (sum >= 9'd255) ? 8'(9'd510 - sum) : sum[7:0];
		end else begin
			den = mx;
		end
	end

	// Divider operands. The quotients fit 17 bits, so the bits of each
	// dividend above the low 17 start out as the remainder.
	always_comb begin
		nxt.hue.rem = 9'(xh[23:17]);
		nxt.hue.sh = xh[16:0];
		nxt.hue.div = {c, 1'b0};
		nxt.sat.rem = {1'b0, c};
		nxt.sat.sh = 17'(den);
		nxt.sat.div = {den, 1'b0};
		nxt.undef = (c == 8'd0);
		nxt.sat_zero = (den == 8'd0);
		nxt.level = mode ? sum : {mx, 1'b0};
	end

	// Stage register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s1 <= nxt;
		end
	end

	assign valid_out = valid_s1;
	assign data_out = data_s1;

endmodule

FILE: hw/rtl/rhh_div_cell.sv
// One cell of the divider chain: a division step on the hue and saturation lanes.
// Depends on rhh_pkg.
module rhh_div_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           valid_in,
	input  rhh_pkg::cell_t data_in,
	output logic           valid_out,
	output rhh_pkg::cell_t data_out
);

	logic           valid_q;
	rhh_pkg::cell_t data_q;
	rhh_pkg::cell_t nxt;

	// Both lanes take one quotient bit; flags and level pass along.
	always_comb begin
		nxt = data_in;
		nxt.hue = rhh_pkg::div_step(data_in.hue);
		nxt.sat = rhh_pkg::div_step(data_in.sat);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= nxt;
		end
	end

	assign valid_out = valid_q;
	assign data_out = data_q;

endmodule

FILE: hw/rtl/rgb_to_hsv_hsl_unit.sv
// RGB to HSV/HSL converter with one front stage and a chain
// of 17 divider cells, each resolving one quotient bit for hue and saturation.
// Throughput is one item per cycle; the whole chain holds while the output
// item waits, and the last cell is the output register.
// Reset (arst_n low, asynchronous) clears all valid bits and sets mode to HSV.
// Depends on rhh_pkg, rhh_front, rhh_div_cell and the macro header.
`include "rgb_to_hsv_hsl_unit_macros.svh"

module rgb_to_hsv_hsl_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [7:0] red, [15:8] green, [23:16] blue
	input  logic [rhh_pkg::IN_DATA_W-1:0]  s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [14:0] hue, [31:15] saturation, [40:32] level, [47:41] zero
	output logic [rhh_pkg::OUT_DATA_W-1:0] m_tdata,
	// [0] hue_undefined
	output logic        m_tuser
);

	logic           mode_q;
	logic           en;
	logic           valid_c [rhh_pkg::DIV_STEPS+1];
	rhh_pkg::cell_t data_c  [rhh_pkg::DIV_STEPS+1];
	rhh_pkg::cell_t last;
	logic [rhh_pkg::HUE_W-1:0] hue;
	logic [rhh_pkg::SAT_W-1:0] sat;

	// Mode register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (cfg_we) begin
			mode_q <= cfg_data;
		end
	end

	// The chain moves whenever the output slot is free or being taken.
	assign en = !m_tvalid || m_tready;
	assign s_tready = en;

	rhh_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.valid_in  (s_tvalid),
		.red       (s_tdata[7:0]),
		.green     (s_tdata[15:8]),
		.blue      (s_tdata[23:16]),
		.mode      (mode_q),
		.valid_out (valid_c[0]),
		.data_out  (data_c[0])
	);

	// Divider chain, one quotient bit per cell.
	for (genvar i = 0; i < rhh_pkg::DIV_STEPS; i++) begin : g_cell
		rhh_div_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.valid_in  (valid_c[i]),
			.data_in   (data_c[i]),
			.valid_out (valid_c[i+1]),
			.data_out  (data_c[i+1])
		);
	end

	// Result formatting. A grey pixel forces hue to zero, and a zero
	// denominator forces saturation to zero. The sector ranges keep the
	// rounded hue below the full circle, so no wrap is needed.
	assign last = data_c[rhh_pkg::DIV_STEPS];
	assign hue = last.undef ? '0 : last.hue.sh[rhh_pkg::HUE_W-1:0];
	assign sat = last.sat_zero ? '0 : last.sat.sh;

	assign m_tvalid = valid_c[rhh_pkg::DIV_STEPS];
	assign m_tdata = {7'd0, last.level, sat, hue};
	assign m_tuser = last.undef;

	// Checks.
	`RHH_ASSERT_IMP(a_undef_zero, m_tvalid && m_tuser, (hue == '0) && (sat == '0))
	`RHH_ASSERT_IMP(a_hue_range, m_tvalid, hue < 15'd23040)
	`RHH_ASSERT_IMP(a_sat_range, m_tvalid, sat <= 17'd65536)
	`RHH_ASSERT(a_ready_link, s_tready == (!m_tvalid || m_tready))

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for the RGB to HSV/HSL converter, top module testbench.
// Drives pixels over the input stream, predicts each result in place and checks
// the output stream field by field. Depends on rhh_pkg and rgb_to_hsv_hsl_unit.
module testbench;

	localparam logic MODE_HSV = 1'b0;
	localparam logic MODE_HSL = 1'b1;
	localparam int   HUE_SECTOR = 3840;
	localparam int   HUE_FULL = 23040;
	localparam int   SAT_ONE = 65536;
	localparam int   PIPE_LATENCY = 18;
	localparam int   PHASE_ITEMS = 475;
	localparam int   NUM_ROWS = 24;

	// One converted pixel as it leaves the block.
	typedef struct packed {
		logic [rhh_pkg::HUE_W-1:0]   hue;
		logic                        undef;
		logic [rhh_pkg::SAT_W-1:0]   sat;
		logic [rhh_pkg::LEVEL_W-1:0] level;
	} hsx_t;

	// A directed pixel; the result is typed in only when known is set.
	typedef struct {
		logic                     mode;
		logic [rhh_pkg::CH_W-1:0] red;
		logic [rhh_pkg::CH_W-1:0] green;
		logic [rhh_pkg::CH_W-1:0] blue;
		bit                       known;
		hsx_t                     res;
	} pixel_row_t;

	// What the driver attaches to each item it offers.
	typedef struct {
		bit   known;
		hsx_t res;
	} typed_res_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_data;
	logic s_tvalid;
	logic s_tready;
	logic [rhh_pkg::IN_DATA_W-1:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [rhh_pkg::OUT_DATA_W-1:0] m_tdata;
	logic m_tuser;

	logic       mode_shadow;
	bit         steady;
	int         mismatch_cnt;
	hsx_t       hsx_expect_q[$];
	typed_res_t typed_res_q[$];

	pixel_row_t pixel_rows [NUM_ROWS] = '{
		'{MODE_HSV, 8'd0, 8'd0, 8'd0, 1'b1, '{15'd0, 1'b1, 17'd0, 9'd0}},
		'{MODE_HSV, 8'd255, 8'd255, 8'd255, 1'b1, '{15'd0, 1'b1, 17'd0, 9'd510}},
		'{MODE_HSV, 8'd128, 8'd128, 8'd128, 1'b1, '{15'd0, 1'b1, 17'd0, 9'd256}},
		'{MODE_HSV, 8'd255, 8'd0, 8'd0, 1'b1, '{15'd0, 1'b0, 17'd65536, 9'd510}},
		'{MODE_HSV, 8'd0, 8'd255, 8'd0, 1'b1, '{15'd7680, 1'b0, 17'd65536, 9'd510}},
		'{MODE_HSV, 8'd0, 8'd0, 8'd255, 1'b1, '{15'd15360, 1'b0, 17'd65536, 9'd510}},
		'{MODE_HSV, 8'd255, 8'd255, 8'd0, 1'b1, '{15'd3840, 1'b0, 17'd65536, 9'd510}},
		'{MODE_HSV, 8'd255, 8'd0, 8'd255, 1'b1, '{15'd19200, 1'b0, 17'd65536, 9'd510}},
		'{MODE_HSV, 8'd0, 8'd255, 8'd255, 1'b1, '{15'd11520, 1'b0, 17'd65536, 9'd510}},
		'{MODE_HSV, 8'd255, 8'd0, 8'd1, 1'b0, '{15'd0, 1'b0, 17'd0, 9'd0}},
		'{MODE_HSV, 8'd255, 8'd1, 8'd0, 1'b0, '{15'd0, 1'b0, 17'd0, 9'd0}},
		'{MODE_HSV, 8'd1, 8'd0, 8'd0, 1'b1, '{15'd0, 1'b0, 17'd65536, 9'd2}},
		'{MODE_HSV, 8'd0, 8'd0, 8'd1, 1'b1, '{15'd15360, 1'b0, 17'd65536, 9'd2}},
		'{MODE_HSV, 8'd200, 8'd100, 8'd50, 1'b0, '{15'd0, 1'b0, 17'd0, 9'd0}},
		'{MODE_HSL, 8'd0, 8'd0, 8'd0, 1'b1, '{15'd0, 1'b1, 17'd0, 9'd0}},
		'{MODE_HSL, 8'd255, 8'd255, 8'd255, 1'b1, '{15'd0, 1'b1, 17'd0, 9'd510}},
		'{MODE_HSL, 8'd255, 8'd0, 8'd0, 1'b1, '{15'd0, 1'b0, 17'd65536, 9'd255}},
		'{MODE_HSL, 8'd0, 8'd255, 8'd0, 1'b1, '{15'd7680, 1'b0, 17'd65536, 9'd255}},
		'{MODE_HSL, 8'd0, 8'd0, 8'd255, 1'b1, '{15'd15360, 1'b0, 17'd65536, 9'd255}},
		'{MODE_HSL, 8'd128, 8'd0, 8'd0, 1'b1, '{15'd0, 1'b0, 17'd65536, 9'd128}},
		'{MODE_HSL, 8'd1, 8'd0, 8'd0, 1'b1, '{15'd0, 1'b0, 17'd65536, 9'd1}},
		'{MODE_HSL, 8'd255, 8'd254, 8'd254, 1'b1, '{15'd0, 1'b0, 17'd65536, 9'd509}},
		'{MODE_HSL, 8'd255, 8'd128, 8'd128, 1'b0, '{15'd0, 1'b0, 17'd0, 9'd0}},
		'{MODE_HSL, 8'd200, 8'd100, 8'd50, 1'b0, '{15'd0, 1'b0, 17'd0, 9'd0}}
	};

	rgb_to_hsv_hsl_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	// Quotient rounded to nearest with ties upward; a zero divisor gives zero.
	function automatic int unsigned round_quot(input int unsigned num, input int unsigned den);
		if (den == 0)
			return 0;
		return (2 * num + den) / (2 * den);
	endfunction

	// Hue, saturation and level of one pixel under the given mode.
	function automatic hsx_t convert_pixel(input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b, input logic mode);
		int unsigned mx;
		int unsigned mn;
		int unsigned c;
		int unsigned num;
		int unsigned hue;
		int unsigned sum;
		int unsigned den;
		hsx_t        o;
		mx = r;
		mn = r;
		if (g > mx) mx = g;
		if (b > mx) mx = b;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
		c = mx - mn;
		hue = 0;
		o.undef = (c == 0);
		if (c != 0) begin
			// Sector priority: green, then blue, then red.
			if (mx == g)
				num = 2 * c + b - r;
			else if (mx == b)
				num = 4 * c + r - g;
			else if (g < b)
				num = 6 * c + g - b;
			else
				num = g - b;
			hue = round_quot(HUE_SECTOR * num, c);
			if (hue >= HUE_FULL)
				hue -= HUE_FULL;
		end
		o.hue = hue[14:0];
		if (mode == MODE_HSV) begin
			o.level = 9'(2 * mx);
			o.sat = 17'(round_quot(SAT_ONE * c, mx));
		end else begin
			sum = mx + mn;
			den = (sum >= 255) ? (510 - sum) : sum;
			o.level = 9'(sum);
			o.sat = 17'(round_quot(SAT_ONE * c, den));
		end
		return o;
	endfunction

	// Random pixel packed as blue, green, red, biased toward greys, ties and extremes.
	function automatic logic [23:0] rand_pixel();
		logic [7:0] v;
		logic [7:0] w;
		logic [7:0] ch [3];
		case ($urandom_range(0, 9))
			0: begin
				v = 8'($urandom);
				ch[0] = v;
				ch[1] = v;
				ch[2] = v;
			end
			1: begin
				for (int i = 0; i < 3; i++)
					ch[i] = $urandom_range(0, 1) ? 8'd255 : 8'd0;
			end
			2: begin
				// Two channels tie, which exercises the sector priority.
				v = 8'($urandom);
				w = 8'($urandom);
				ch[0] = v;
				ch[1] = v;
				ch[2] = v;
				ch[$urandom_range(0, 2)] = w;
			end
			3: begin
				for (int i = 0; i < 3; i++)
					case ($urandom_range(0, 3))
						0: ch[i] = 8'd0;
						1: ch[i] = 8'd1;
						2: ch[i] = 8'd254;
						default: ch[i] = 8'd255;
					endcase
			end
			default: begin
				for (int i = 0; i < 3; i++)
					ch[i] = 8'($urandom);
			end
		endcase
		return {ch[2], ch[1], ch[0]};
	endfunction

	// Idle length in cycles: none in a steady phase, else mostly none or short, now and then long.
	function automatic int idle_len();
		int k;
		if (steady)
			return 0;
		k = $urandom_range(0, 99);
		if (k < 55)
			return 0;
		if (k < 85)
			return $urandom_range(1, 3);
		if (k < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Offer one pixel and wait until it is accepted.
	task automatic send_pixel(input logic [23:0] pix, input bit known, input hsx_t res);
		int gap;
		typed_res_t t;
		gap = idle_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		t.known = known;
		t.res = res;
		typed_res_q.push_back(t);
		s_tvalid <= 1'b1;
		s_tdata <= pix;
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	// Stop sending and wait for every outstanding result. The first edge lets
	// the input monitor record an item that was accepted just now.
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (hsx_expect_q.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	// Write the mode register; the block is idle here.
	task automatic write_mode(input logic m);
		cfg_we <= 1'b1;
		cfg_data <= m;
		@(posedge clk);
		cfg_we <= 1'b0;
		mode_shadow = m;
	endtask

	// Clock.
	initial begin
		clk = 1'b0;
	end
	always #5 clk = ~clk;

	// Record the expected result of every accepted pixel.
	always @(posedge clk) begin : in_monitor
		typed_res_t t;
		if (arst_n && s_tvalid && s_tready) begin
			t.known = 1'b0;
			if (typed_res_q.size() != 0)
				t = typed_res_q.pop_front();
			if (t.known)
				hsx_expect_q.push_back(t.res);
			else
				hsx_expect_q.push_back(convert_pixel(s_tdata[7:0], s_tdata[15:8],
					s_tdata[23:16], mode_shadow));
		end
	end

	// Compare every accepted result with the oldest expectation.
	always @(posedge clk) begin : out_checker
		hsx_t got;
		hsx_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.hue = m_tdata[14:0];
			got.sat = m_tdata[31:15];
			got.level = m_tdata[40:32];
			got.undef = m_tuser;
			if (hsx_expect_q.size() == 0) begin
				mismatch_cnt++;
				$display("%0t: unexpected result hue=%0d undef=%0b sat=%0d level=%0d",
					$time, got.hue, got.undef, got.sat, got.level);
			end else begin
				want = hsx_expect_q.pop_front();
				if (got.hue !== want.hue) begin
					mismatch_cnt++;
					$display("%0t: hue expected %0d got %0d", $time, want.hue, got.hue);
				end
				if (got.undef !== want.undef) begin
					mismatch_cnt++;
					$display("%0t: hue_undefined expected %0b got %0b", $time,
						want.undef, got.undef);
				end
				if (got.sat !== want.sat) begin
					mismatch_cnt++;
					$display("%0t: saturation expected %0d got %0d", $time,
						want.sat, got.sat);
				end
				if (got.level !== want.level) begin
					mismatch_cnt++;
					$display("%0t: level expected %0d got %0d", $time,
						want.level, got.level);
				end
				if (m_tdata[47:41] !== 7'd0) begin
					mismatch_cnt++;
					$display("%0t: pad bits expected 0 got %0h", $time, m_tdata[47:41]);
				end
			end
		end
	end

	// Output back-pressure with random stall lengths.
	initial begin
		m_tready = 1'b0;
		forever begin
			int stall;
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 30)) @(posedge clk);
			stall = idle_len();
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	// Run limit.
	initial begin
		#12000000;
		$display("[rgb_to_hsv_hsl_unit] ERROR");
		$finish;
	end

	// Main sequence: reset, directed table, random phases in both modes.
	initial begin
		hsx_t none;
		none = '0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_data = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		mode_shadow = MODE_HSV;
		steady = 1'b0;
		mismatch_cnt = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The first rows rely on the mode after reset.
		for (int i = 0; i < NUM_ROWS; i++) begin
			if (pixel_rows[i].mode != mode_shadow) begin
				drain();
				write_mode(pixel_rows[i].mode);
			end
			send_pixel({pixel_rows[i].blue, pixel_rows[i].green, pixel_rows[i].red},
				pixel_rows[i].known, pixel_rows[i].res);
		end

		// Alternate modes; one phase runs without any idling.
		for (int ph = 0; ph < 4; ph++) begin
			drain();
			write_mode((ph % 2 == 0) ? MODE_HSV : MODE_HSL);
			steady = (ph == 2);
			for (int n = 0; n < PHASE_ITEMS; n++)
				send_pixel(rand_pixel(), 1'b0, none);
		end
		steady = 1'b0;

		drain();
		repeat (PIPE_LATENCY + 20) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("[rgb_to_hsv_hsl_unit] OK");
		else
			$display("[rgb_to_hsv_hsl_unit] ERROR");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/rhh_pkg.sv
hw/rtl/rhh_front.sv
hw/rtl/rhh_div_cell.sv
hw/rtl/rgb_to_hsv_hsl_unit.sv
dv/testbench.sv
